FILE: sv/vhtp_pkg.sv
`default_nettype none

package vhtp_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned SizeW   = 16;
    localparam int unsigned CompW   = 32;
    localparam int unsigned RoundW  = 64;
    localparam int unsigned StreamW = 32;

    localparam int unsigned SeedSize   = 32;
    localparam int unsigned IvSize     = 16;
    localparam int unsigned CipherLen  = 16;
    localparam int unsigned StreamSalsa = 2;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MAGIC    = 3'd1;
    localparam logic [2:0] ST_VERSION  = 3'd2;
    localparam logic [2:0] ST_SIZE     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_CIPHER   = 3'd5;
    localparam logic [2:0] ST_STREAM   = 3'd6;

    // record types
    localparam logic [7:0] T_END     = 8'd0;
    localparam logic [7:0] T_CIPHER  = 8'd2;
    localparam logic [7:0] T_COMP    = 8'd3;
    localparam logic [7:0] T_SEED    = 8'd4;
    localparam logic [7:0] T_TSEED   = 8'd5;
    localparam logic [7:0] T_ROUNDS  = 8'd6;
    localparam logic [7:0] T_IV      = 8'd7;
    localparam logic [7:0] T_KEY     = 8'd8;
    localparam logic [7:0] T_START   = 8'd9;
    localparam logic [7:0] T_STREAM  = 8'd10;

    localparam logic [7:0] MAGIC_BYTES [8] = '{
        8'h03, 8'hD9, 8'hA2, 8'h9A, 8'h67, 8'hFB, 8'h4B, 8'hB5
    };

    localparam logic [7:0] AES_ID [16] = '{
        8'h31, 8'hc1, 8'hf2, 8'he6, 8'hbf, 8'h71, 8'h43, 8'h50,
        8'hbe, 8'h58, 8'h05, 8'h21, 8'h6a, 8'hfc, 8'h5a, 8'hff
    };

    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic [3:0]         field_id;
        logic [SizeW-1:0]   byte_offset;
        logic [ByteW-1:0]   field_byte;
        logic [2:0]         status;
        logic [CompW-1:0]   compression;
        logic [RoundW-1:0]  rounds;
        logic [StreamW-1:0] stream;
    } vhtp_res_t;

    // required data size of a passed-out record, zero for other types
    function automatic logic [SizeW-1:0] wanted_size(input logic [7:0] t);
        logic [SizeW-1:0] w;
        w = '0;
        if (t == T_SEED || t == T_TSEED || t == T_KEY || t == T_START)
            w = SizeW'(SeedSize);
        else if (t == T_IV)
            w = SizeW'(IvSize);
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/vhtp_core.sv
`default_nettype none

module vhtp_core
    import vhtp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [ByteW-1:0] data_byte,
    input  wire logic             first,
    output vhtp_res_t             res
);

    localparam logic [2:0] PH_PREAMBLE = 3'd0;
    localparam logic [2:0] PH_TYPE     = 3'd1;
    localparam logic [2:0] PH_SIZE_LO  = 3'd2;
    localparam logic [2:0] PH_SIZE_HI  = 3'd3;
    localparam logic [2:0] PH_DATA     = 3'd4;
    localparam logic [2:0] PH_HALT     = 3'd5;

    logic [2:0]         phase_reg, phase_next;
    logic [3:0]         pcount_reg, pcount_next;
    logic [7:0]         rtype_reg, rtype_next;
    logic [SizeW-1:0]   rsize_reg, rsize_next;
    logic [SizeW-1:0]   doff_reg, doff_next;
    logic [CompW-1:0]   comp_reg, comp_next;
    logic [RoundW-1:0]  rounds_reg, rounds_next;
    logic [StreamW-1:0] sid_reg, sid_next;
    logic               cok_reg, cok_next;
    logic [7:0]         vlow_reg, vlow_next;

    logic [2:0]         cur_phase;
    logic [3:0]         cur_pcount;
    logic [7:0]         cur_rtype;
    logic [SizeW-1:0]   cur_rsize;
    logic [SizeW-1:0]   cur_doff;
    logic [CompW-1:0]   cur_comp;
    logic [RoundW-1:0]  cur_rounds;
    logic [StreamW-1:0] cur_sid;
    logic               cur_cok;
    logic [7:0]         cur_vlow;

    logic               finish;
    logic               emitted;
    logic [SizeW:0]     off_inc;
    logic [SizeW-1:0]   size_full;
    logic [SizeW-1:0]   want;
    logic [15:0]        version;

    always_comb
    begin
        // a first byte restarts from the reset state
        if (first)
        begin
            cur_phase  = PH_PREAMBLE;
            cur_pcount = '0;
            cur_rtype  = '0;
            cur_rsize  = '0;
            cur_doff   = '0;
            cur_comp   = '0;
            cur_rounds = RoundW'(1);
            cur_sid    = '0;
            cur_cok    = 1'b0;
            cur_vlow   = '0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_pcount = pcount_reg;
            cur_rtype  = rtype_reg;
            cur_rsize  = rsize_reg;
            cur_doff   = doff_reg;
            cur_comp   = comp_reg;
            cur_rounds = rounds_reg;
            cur_sid    = sid_reg;
            cur_cok    = cok_reg;
            cur_vlow   = vlow_reg;
        end

        phase_next  = cur_phase;
        pcount_next = cur_pcount;
        rtype_next  = cur_rtype;
        rsize_next  = cur_rsize;
        doff_next   = cur_doff;
        comp_next   = cur_comp;
        rounds_next = cur_rounds;
        sid_next    = cur_sid;
        cok_next    = cur_cok;
        vlow_next   = cur_vlow;

        res       = '0;
        finish    = 1'b0;
        emitted   = 1'b0;
        off_inc   = {1'b0, cur_doff} + (SizeW+1)'(1);
        size_full = {data_byte, cur_rsize[7:0]};
        want      = wanted_size(cur_rtype);
        version   = {data_byte, cur_vlow};

        unique case (cur_phase)
            PH_PREAMBLE:
            begin
                pcount_next = cur_pcount + 4'd1;
                if (cur_pcount < 4'd8)
                begin
                    if (data_byte != MAGIC_BYTES[cur_pcount[2:0]])
                    begin
                        res.valid   = 1'b1;
                        res.kind    = KIND_ERR;
                        res.status  = ST_MAGIC;
                        phase_next  = PH_HALT;
                        pcount_next = cur_pcount;
                    end
                end
                else if (cur_pcount == 4'd10)
                begin
                    vlow_next = data_byte;
                end
                else if (cur_pcount == 4'd11)
                begin
                    if (version != 16'd2 && version != 16'd3)
                    begin
                        res.valid   = 1'b1;
                        res.kind    = KIND_ERR;
                        res.status  = ST_VERSION;
                        phase_next  = PH_HALT;
                        pcount_next = cur_pcount;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
            end
            PH_TYPE:
            begin
                rtype_next = data_byte;
                phase_next = PH_SIZE_LO;
            end
            PH_SIZE_LO:
            begin
                rsize_next = {8'd0, data_byte};
                phase_next = PH_SIZE_HI;
            end
            PH_SIZE_HI:
            begin
                rsize_next = size_full;
                doff_next  = '0;
                if (cur_rtype == T_CIPHER)
                    cok_next = (size_full == SizeW'(CipherLen));
                else if (cur_rtype == T_COMP)
                    comp_next = '0;
                else if (cur_rtype == T_ROUNDS)
                    rounds_next = '0;
                else if (cur_rtype == T_STREAM)
                    sid_next = '0;
                if (size_full == '0)
                    finish = 1'b1;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (cur_rtype == T_CIPHER)
                begin
                    if (cur_doff < SizeW'(CipherLen) && data_byte != AES_ID[cur_doff[3:0]])
                        cok_next = 1'b0;
                end
                else if (cur_rtype == T_COMP)
                begin
                    if (cur_doff < SizeW'(4))
                        comp_next[{cur_doff[1:0], 3'b000} +: 8] =
                            cur_comp[{cur_doff[1:0], 3'b000} +: 8] | data_byte;
                end
                else if (cur_rtype == T_ROUNDS)
                begin
                    if (cur_doff < SizeW'(8))
                        rounds_next[{cur_doff[2:0], 3'b000} +: 8] =
                            cur_rounds[{cur_doff[2:0], 3'b000} +: 8] | data_byte;
                end
                else if (cur_rtype == T_STREAM)
                begin
                    if (cur_doff < SizeW'(4))
                        sid_next[{cur_doff[1:0], 3'b000} +: 8] =
                            cur_sid[{cur_doff[1:0], 3'b000} +: 8] | data_byte;
                end
                else if (want != '0 && cur_rsize == want)
                begin
                    emitted         = 1'b1;
                    res.valid       = 1'b1;
                    res.kind        = KIND_BYTE;
                    res.field_id    = cur_rtype[3:0];
                    res.byte_offset = cur_doff;
                    res.field_byte  = data_byte;
                end
                if (off_inc >= {1'b0, cur_rsize})
                begin
                    if (emitted)
                        phase_next = PH_TYPE;
                    else
                        finish = 1'b1;
                end
                else
                begin
                    doff_next = off_inc[SizeW-1:0];
                end
            end
            default:
            begin
                // halted: drop bytes until the next first byte
            end
        endcase

        if (finish)
        begin
            phase_next = PH_TYPE;
            if (cur_rtype == T_END)
            begin
                res.valid  = 1'b1;
                phase_next = PH_HALT;
                if (!cok_next)
                begin
                    res.kind   = KIND_ERR;
                    res.status = ST_CIPHER;
                end
                else if (sid_next != StreamW'(StreamSalsa))
                begin
                    res.kind   = KIND_ERR;
                    res.status = ST_STREAM;
                end
                else
                begin
                    res.kind   = KIND_DONE;
                    res.status = ST_OK;
                end
            end
            else if (cur_rtype > T_STREAM)
            begin
                res.valid    = 1'b1;
                res.kind     = KIND_ERR;
                res.field_id = cur_rtype[3:0];
                res.status   = ST_UNKNOWN;
                phase_next   = PH_HALT;
            end
            else if (want != '0 && rsize_next != want)
            begin
                res.valid    = 1'b1;
                res.kind     = KIND_ERR;
                res.field_id = cur_rtype[3:0];
                res.status   = ST_SIZE;
                phase_next   = PH_HALT;
            end
        end

        res.compression = comp_next;
        res.rounds      = rounds_next;
        res.stream      = sid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PREAMBLE;
            pcount_reg <= '0;
            rtype_reg  <= '0;
            rsize_reg  <= '0;
            doff_reg   <= '0;
            comp_reg   <= '0;
            rounds_reg <= RoundW'(1);
            sid_reg    <= '0;
            cok_reg    <= 1'b0;
            vlow_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            pcount_reg <= pcount_next;
            rtype_reg  <= rtype_next;
            rsize_reg  <= rsize_next;
            doff_reg   <= doff_next;
            comp_reg   <= comp_next;
            rounds_reg <= rounds_next;
            sid_reg    <= sid_next;
            cok_reg    <= cok_next;
            vlow_reg   <= vlow_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/vault_header_tlv_parser.sv
// Path: a byte transferred into the input register is parsed from there, and
// its result, if any, is written to the result register that drives the port.
// Throughput: one byte per cycle while the output is not stalled, through the
// parse step between the input register and the result register.
// Reset: rst_n clears the parser state and both valid flags at once.
`default_nettype none

module vault_header_tlv_parser
    import vhtp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [ByteW-1:0]   data_byte,
    input  wire logic               first,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              kind,
    output logic [3:0]              field_id,
    output logic [SizeW-1:0]        byte_offset,
    output logic [ByteW-1:0]        field_byte,
    output logic [2:0]              status,
    output logic [CompW-1:0]        compression,
    output logic [RoundW-1:0]       transform_rounds,
    output logic [StreamW-1:0]      stream_type
);

    logic             in_vld_reg;
    logic [ByteW-1:0] byte_reg;
    logic             first_reg;
    logic             out_vld_reg;
    vhtp_res_t        res;
    vhtp_res_t        res_reg;
    logic             fire;

    // advance the parse stage when a byte is held and the result register can take a result
    assign fire     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= data_byte;
            first_reg <= first;
        end
    end

    vhtp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .data_byte (byte_reg),
        .first     (first_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (fire && res.valid)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
            res_reg <= res;
    end

    assign out_valid        = out_vld_reg;
    assign kind             = res_reg.kind;
    assign field_id         = res_reg.field_id;
    assign byte_offset      = res_reg.byte_offset;
    assign field_byte       = res_reg.field_byte;
    assign status           = res_reg.status;
    assign compression      = res_reg.compression;
    assign transform_rounds = res_reg.rounds;
    assign stream_type      = res_reg.stream;

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |-> status == ST_OK)
        else $error("field byte carries a nonzero status");

    a_byte_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |->
            (field_id == T_SEED[3:0] || field_id == T_TSEED[3:0] ||
             field_id == T_IV[3:0] || field_id == T_KEY[3:0] ||
             field_id == T_START[3:0]))
        else $error("field byte from a record that is not passed out");

    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERR |-> status != ST_OK)
        else $error("error result without an error status");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |-> status == ST_OK && field_id == 4'd0
            && stream_type == StreamW'(StreamSalsa))
        else $error("header finished with a bad verdict");

endmodule

`default_nettype wire
